// ===== rtl/eog_artifact_event_detector_core_macros.svh =====
// Assertion macros for the eye-movement artifact event detector.
// Included by the top level; no other dependencies.
`ifndef EOG_ARTIFACT_EVENT_DETECTOR_CORE_MACROS_SVH
`define EOG_ARTIFACT_EVENT_DETECTOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define EOGAD_ASSERT_NOW(label, clk, rst, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("eogad check failed");
// Next-cycle implication.
`define EOGAD_ASSERT_NEXT(label, clk, rst, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("eogad check failed");
`else
`define EOGAD_ASSERT_NOW(label, clk, rst, ant, cons)
`define EOGAD_ASSERT_NEXT(label, clk, rst, ant, cons)
`endif
`endif

// ===== rtl/eogad_pkg.sv =====
// Shared types and constants for the eye-movement artifact event detector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eogad_pkg;

  // Field widths fixed by the item and register formats.
  localparam int THR_W      = 24;
  localparam int HOLD_W     = 16;
  localparam int CODE_W     = 15;
  localparam int CHAN_W     = 4;
  localparam int WORD_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Output word queue.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic [WORD_W-1:0] OFF_FLAG = 16'h8000;

  // Item kinds.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_HOLD      = 3'd1,
    CFG_CODE      = 3'd2,
    CFG_LEFT      = 3'd3,
    CFG_RIGHT     = 3'd4
  } cfg_idx_t;

  // Register reset values.
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 24'd30;
  localparam logic [HOLD_W-1:0] HOLD_RST      = 16'd1024;
  localparam logic [CODE_W-1:0] CODE_RST      = 15'd1024;
  localparam logic [CHAN_W-1:0] LEFT_RST      = 4'd11;
  localparam logic [CHAN_W-1:0] RIGHT_RST     = 4'd15;

  typedef struct packed {
    logic [WORD_W-1:0] event_word;
    logic              last_result;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/eogad_ifs.sv =====
// Valid/ready channel interfaces for sample/tick words and event words.
// Depends on eogad_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface eogad_in_if
  import eogad_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [CHAN_W-1:0]             channel;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          frame_end;

  modport source (output valid, output func, output channel, output sample,
                  output frame_end, input ready);
  modport sink   (input valid, input func, input channel, input sample,
                  input frame_end, output ready);
endinterface

interface eogad_out_if
  import eogad_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] event_word;
  logic              last_result;

  modport source (output valid, output event_word, output last_result, input ready);
  modport sink   (input valid, input event_word, input last_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/eog_artifact_event_detector_core.sv =====
// Eye-movement artifact event detector: top level.
// Depends on eogad_pkg, eogad_ifs and the assertion macro header.
// Use:
//   items  - sink channel. A word is either a channel sample (func = 0) of a
//            channel-interleaved frame, or a time tick (func = 1).
//   events - source channel. Event words: event_code on a detection,
//            event_code + 0x8000 when the hold-off timer runs out.
//            last_result marks the final word caused by one tick.
//   cfg_*  - register writes (threshold, hold_ticks, event_code, left and
//            right channel), taken at any edge with cfg_write high; write
//            them only while the block is idle.
// Path: a word is captured in the input register and evaluated there; when
//   it advances, its event words enter a 4-deep output queue, which offers
//   them in order.
// Throughput: one input word per cycle. Sample words never produce output.
//   A tick produces up to two words; the output side drains one per cycle,
//   and the input register only advances while the queue has room for two.
// Reset: registers to defaults, timer idle with period_over set, other flags cleared, queue empty.
// Stall on events: words wait in the queue; items drops ready when it has no room for two.
`timescale 1ns / 1ps
`default_nettype none

`include "eog_artifact_event_detector_core_macros.svh"

module eog_artifact_event_detector_core
  import eogad_pkg::*;
#(
  parameter int CHANNEL_COUNT = 16,
  parameter int SAMPLE_BITS   = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  eogad_in_if.sink              items,
  eogad_out_if.source           events,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Compare width: covers sum/difference of two samples and 2*threshold, plus sign.
  localparam int SUM_W = (SAMPLE_BITS + 1 > THR_W + 1) ? SAMPLE_BITS + 1 : THR_W + 1;
  localparam int CW    = SUM_W + 1;

  // ---------------- configuration registers ----------------
  logic [THR_W-1:0]  threshold;
  logic [HOLD_W-1:0] hold_ticks;
  logic [CODE_W-1:0] event_code;
  logic [CHAN_W-1:0] left_channel;
  logic [CHAN_W-1:0] right_channel;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RST;
      hold_ticks    <= HOLD_RST;
      event_code    <= CODE_RST;
      left_channel  <= LEFT_RST;
      right_channel <= RIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_THRESHOLD: threshold     <= cfg_data[THR_W-1:0];
        CFG_HOLD:      hold_ticks    <= cfg_data[HOLD_W-1:0];
        CFG_CODE:      event_code    <= cfg_data[CODE_W-1:0];
        CFG_LEFT:      left_channel  <= cfg_data[CHAN_W-1:0];
        CFG_RIGHT:     right_channel <= cfg_data[CHAN_W-1:0];
        default: ;     // unmapped index: dropped
      endcase
    end
  end

  // ---------------- input register ----------------
  logic                          s1_valid;
  logic                          s1_func;
  logic [CHAN_W-1:0]             s1_channel;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic                          s1_frame_end;
  logic                          s1_fire;

  logic [FIFO_CW-1:0] fifo_count;
  logic               pop;

  // Advance only when the queue can take the worst case of two words.
  assign s1_fire     = s1_valid && (fifo_count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign items.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_func      <= items.func;
      s1_channel   <= items.channel;
      s1_sample    <= items.sample;
      s1_frame_end <= items.frame_end;
    end
  end

  // ---------------- detector state ----------------
  logic signed [SAMPLE_BITS-1:0] left_hold;
  logic signed [SAMPLE_BITS-1:0] right_hold;
  logic                          frame_hit;
  logic                          detected;
  logic                          period_over;
  logic                          timer_on;
  logic [HOLD_W-1:0]             ticks_left;

  // Sample path: hold values including this word, then the two threshold tests.
  logic [CHAN_W-1:0]             later;
  logic                          ch_ok;
  logic                          is_left;
  logic                          is_right;
  logic signed [SAMPLE_BITS-1:0] l_val;
  logic signed [SAMPLE_BITS-1:0] r_val;
  logic signed [CW-1:0]          diff;
  logic signed [CW-1:0]          sum;
  logic signed [CW-1:0]          thr;
  logic signed [CW-1:0]          thr2;
  logic                          hit;

  always_comb begin
    later    = (left_channel > right_channel) ? left_channel : right_channel;
    ch_ok    = int'(s1_channel) < CHANNEL_COUNT;
    is_left  = ch_ok && (s1_channel == left_channel);
    is_right = ch_ok && (s1_channel == right_channel);
    l_val    = is_left  ? s1_sample : left_hold;
    r_val    = is_right ? s1_sample : right_hold;
    diff     = CW'(l_val) - CW'(r_val);
    sum      = CW'(l_val) + CW'(r_val);
    thr      = CW'(signed'({1'b0, threshold}));
    thr2     = thr <<< 1;
    // |x| >= t written as x >= t or -x >= t
    hit      = ch_ok && (s1_channel == later) &&
               ((diff >= thr) || (-diff >= thr) || (sum >= thr2) || (-sum >= thr2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_hold  <= '0;
      right_hold <= '0;
      frame_hit  <= 1'b0;
      detected   <= 1'b0;
    end else if (s1_fire && (s1_func == FUNC_SAMPLE)) begin
      if (is_left) begin
        left_hold <= s1_sample;
      end
      if (is_right) begin
        right_hold <= s1_sample;
      end
      if (s1_frame_end) begin
        detected  <= frame_hit || hit;
        frame_hit <= 1'b0;
      end else if (hit) begin
        frame_hit <= 1'b1;
      end
    end
  end

  // Tick path: expiry first, then a possible restart on detection.
  logic              off_event;
  logic              on_event;
  logic              timer_on_next;
  logic              period_over_next;
  logic [HOLD_W-1:0] ticks_left_next;

  always_comb begin
    off_event        = timer_on && (ticks_left <= HOLD_W'(1));
    on_event         = detected && (period_over || off_event);
    timer_on_next    = timer_on;
    period_over_next = period_over;
    ticks_left_next  = ticks_left;
    if (on_event) begin
      timer_on_next    = 1'b1;
      period_over_next = 1'b0;
      ticks_left_next  = hold_ticks;
    end else if (off_event) begin
      timer_on_next    = 1'b0;
      period_over_next = 1'b1;
      ticks_left_next  = '0;
    end else if (timer_on) begin
      ticks_left_next  = ticks_left - HOLD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_on    <= 1'b0;
      period_over <= 1'b1;
      ticks_left  <= '0;
    end else if (s1_fire && (s1_func == FUNC_TICK)) begin
      timer_on    <= timer_on_next;
      period_over <= period_over_next;
      ticks_left  <= ticks_left_next;
    end
  end

  // Event words produced by this tick, in order.
  logic    [1:0] push_n;
  result_t       res0;
  result_t       res1;

  always_comb begin
    push_n = 2'd0;
    res0   = '{event_word: {1'b0, event_code}, last_result: 1'b1};
    res1   = '{event_word: {1'b0, event_code}, last_result: 1'b1};
    if (s1_fire && (s1_func == FUNC_TICK)) begin
      if (off_event) begin
        res0.event_word  = OFF_FLAG | {1'b0, event_code};
        res0.last_result = !on_event;
        push_n           = on_event ? 2'd2 : 2'd1;
      end else if (on_event) begin
        push_n = 2'd1;
      end
    end
  end

  // ---------------- output queue ----------------
  result_t            fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] fifo_count_next;

  assign events.valid       = (fifo_count != '0);
  assign events.event_word  = fifo_mem[rd_ptr].event_word;
  assign events.last_result = fifo_mem[rd_ptr].last_result;
  assign pop                = events.valid && events.ready;
  assign fifo_count_next    = fifo_count + FIFO_CW'(push_n) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + FIFO_AW'(push_n);
      rd_ptr     <= rd_ptr + FIFO_AW'(pop);
      fifo_count <= fifo_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr + FIFO_AW'(1)] <= res1;
    end
  end

  // ---------------- assertions ----------------
  `EOGAD_ASSERT_NOW(a_timer_phase, clk, rst, 1'b1, timer_on != period_over)
  `EOGAD_ASSERT_NOW(a_idle_count_clear, clk, rst, !timer_on, ticks_left == '0)
  `EOGAD_ASSERT_NOW(a_fifo_bound, clk, rst, 1'b1, fifo_count <= FIFO_CW'(FIFO_DEPTH))
  `EOGAD_ASSERT_NEXT(a_sample_silent, clk, rst, (s1_fire && (s1_func == FUNC_SAMPLE) && !pop),
                     fifo_count == $past(fifo_count))

endmodule

`default_nettype wire

// ===== tb/sv/tb_eog_artifact_event_detector_core.sv =====
// Testbench for eog_artifact_event_detector_core: drives sample and tick words,
// predicts the event words and checks them in order.
// Depends on eogad_pkg, eogad_ifs and the block itself.
`timescale 1ns / 1ps

module tb_eog_artifact_event_detector_core;
  import eogad_pkg::*;

  localparam int SAMPLE_BITS = 24;
  localparam int CHANNELS    = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;     // input reg + eval + queue, with margin
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 116;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [THR_W-1:0] THR_MAX = '1;

  // One word on the items channel.
  typedef struct packed {
    logic                          func;
    logic [CHAN_W-1:0]             channel;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;
  } item_word_t;

  // Tracks the detector state, queues the event words each accepted word
  // must produce, and checks the words that come out.
  class event_tracker;
    logic [THR_W-1:0]              threshold;
    logic [HOLD_W-1:0]             hold_ticks;
    logic [CODE_W-1:0]             event_code;
    logic [CHAN_W-1:0]             left_ch;
    logic [CHAN_W-1:0]             right_ch;
    logic signed [SAMPLE_BITS-1:0] left_val;
    logic signed [SAMPLE_BITS-1:0] right_val;
    bit                            frame_hit;
    bit                            detected;
    bit                            period_over;
    bit                            timer_on;
    logic [HOLD_W-1:0]             ticks_left;
    result_t                       expected_events[$];
    int                            mismatches;

    function new();
      threshold   = THRESHOLD_RST;
      hold_ticks  = HOLD_RST;
      event_code  = CODE_RST;
      left_ch     = LEFT_RST;
      right_ch    = RIGHT_RST;
      left_val    = '0;
      right_val   = '0;
      frame_hit   = 1'b0;
      detected    = 1'b0;
      period_over = 1'b1;
      timer_on    = 1'b0;
      ticks_left  = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_THRESHOLD: threshold  = data[THR_W-1:0];
        CFG_HOLD:      hold_ticks = data[HOLD_W-1:0];
        CFG_CODE:      event_code = data[CODE_W-1:0];
        CFG_LEFT:      left_ch    = data[CHAN_W-1:0];
        CFG_RIGHT:     right_ch   = data[CHAN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_word(item_word_t w);
      logic [CHAN_W-1:0] later;
      longint            l, r, t, diff, sum;
      bit                off_ev, on_ev;
      result_t           res;
      if (w.func == FUNC_SAMPLE) begin
        later = (left_ch > right_ch) ? left_ch : right_ch;
        if (int'(w.channel) < CHANNELS) begin
          if (w.channel == left_ch) left_val = w.sample;
          if (w.channel == right_ch) right_val = w.sample;
          if (w.channel == later) begin
            l    = longint'(left_val);
            r    = longint'(right_val);
            t    = longint'(threshold);
            diff = (l - r < 0) ? r - l : l - r;
            sum  = (l + r < 0) ? -(l + r) : l + r;
            if (diff >= t || sum >= 2 * t) frame_hit = 1'b1;
          end
        end
        if (w.frame_end) begin
          detected  = frame_hit;
          frame_hit = 1'b0;
        end
      end else begin
        off_ev = 1'b0;
        on_ev  = 1'b0;
        if (timer_on) begin
          if (ticks_left <= HOLD_W'(1)) begin
            timer_on    = 1'b0;
            ticks_left  = '0;
            period_over = 1'b1;
            off_ev      = 1'b1;
          end else begin
            ticks_left = ticks_left - HOLD_W'(1);
          end
        end
        if (detected && period_over) begin
          on_ev       = 1'b1;
          timer_on    = 1'b1;
          ticks_left  = hold_ticks;
          period_over = 1'b0;
        end
        if (off_ev) begin
          res.event_word  = OFF_FLAG | {1'b0, event_code};
          res.last_result = !on_ev;
          expected_events.push_back(res);
        end
        if (on_ev) begin
          res.event_word  = {1'b0, event_code};
          res.last_result = 1'b1;
          expected_events.push_back(res);
        end
      end
    endfunction

    function void check_event(result_t got);
      result_t want;
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] event word %h last %0b with nothing pending",
                   $realtime, got.event_word, got.last_result);
      end else begin
        want = expected_events.pop_front();
        if (got.event_word !== want.event_word || got.last_result !== want.last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] event mismatch: expected word %h last %0b, got word %h last %0b",
                     $realtime, want.event_word, want.last_result,
                     got.event_word, got.last_result);
        end
      end
    endfunction

    function int pending_count();
      return expected_events.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  eogad_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) items_if ();
  eogad_out_if events_if ();

  event_tracker sb;

  // Idle/stall odds in percent, changed per phase by the stimulus process.
  int src_idle_pct;
  int snk_stall_pct;

  eog_artifact_event_detector_core #(
    .CHANNEL_COUNT(CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .items    (items_if),
    .events   (events_if),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit: far above the slowest legal run at these item counts.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver side: ready toggles at random while a stall phase is active.
  initial begin
    events_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      events_if.ready <= (int'($urandom_range(99, 0)) >= snk_stall_pct);
    end
  end

  // Event words are taken at the edge where valid and ready are both high;
  // values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst && events_if.valid && events_if.ready)
      sb.check_event(result_t'{events_if.event_word, events_if.last_result});
  end

  // Offers one word, with optional idle cycles first, and returns at the edge
  // where it is taken. valid is left high; the next call or a drain decides.
  task automatic send_word(input item_word_t w);
    while (int'($urandom_range(99, 0)) < src_idle_pct) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid     <= 1'b1;
    items_if.func      <= w.func;
    items_if.channel   <= w.channel;
    items_if.sample    <= w.sample;
    items_if.frame_end <= w.frame_end;
    do @(posedge clk); while (!items_if.ready);
    sb.note_word(w);
  endtask

  task automatic send_sample(input logic [CHAN_W-1:0] ch,
                             input logic signed [SAMPLE_BITS-1:0] v, input logic fe);
    send_word('{func: FUNC_SAMPLE, channel: ch, sample: v, frame_end: fe});
  endtask

  // Channel, sample and frame_end are don't-care on a tick; fill them randomly.
  task automatic send_tick();
    send_word('{func: FUNC_TICK, channel: CHAN_W'($urandom),
                sample: SAMPLE_BITS'($urandom), frame_end: 1'($urandom)});
  endtask

  // Drop valid, wait for every predicted word to come out, then let the
  // pipeline settle, since sample words leave nothing to wait on.
  task automatic drain();
    items_if.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all five registers back to back plus one write to an unused index.
  // Upper data bits beyond each register width carry junk.
  task automatic program_regs(input logic [THR_W-1:0] thr, input logic [HOLD_W-1:0] hold,
                              input logic [CODE_W-1:0] code,
                              input logic [CHAN_W-1:0] lch, input logic [CHAN_W-1:0] rch);
    logic [CFG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    drain();
    idx[0] = CFG_THRESHOLD;  val[0] = thr;
    idx[1] = CFG_HOLD;       val[1] = CFG_DATA_W'($urandom);  val[1][HOLD_W-1:0] = hold;
    idx[2] = CFG_CODE;       val[2] = CFG_DATA_W'($urandom);  val[2][CODE_W-1:0] = code;
    idx[3] = CFG_LEFT;       val[3] = CFG_DATA_W'($urandom);  val[3][CHAN_W-1:0] = lch;
    idx[4] = CFG_RIGHT;      val[4] = CFG_DATA_W'($urandom);  val[4][CHAN_W-1:0] = rch;
    idx[5] = CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, int'(CFG_RIGHT) + 1));
    val[5] = CFG_DATA_W'($urandom);
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_write <= 1'b0;
  endtask

  // Sample values: mostly within +/-span, with full-scale and random outliers.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int span);
    case ($urandom_range(9, 0))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_BITS'($urandom);
      default: return SAMPLE_BITS'(int'($urandom_range(2 * span, 0)) - span);
    endcase
  endfunction

  initial begin
    int                ph, sent, len, later, burst, span;
    logic [THR_W-1:0]  thr;
    logic [HOLD_W-1:0] hold;
    logic [CODE_W-1:0] code;
    logic [CHAN_W-1:0] lch, rch;
    bit                drop_end;

    sb = new();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    rst                <= 1'b1;
    items_if.valid     <= 1'b0;
    items_if.func      <= FUNC_SAMPLE;
    items_if.channel   <= '0;
    items_if.sample    <= '0;
    items_if.frame_end <= 1'b0;
    cfg_write          <= 1'b0;
    cfg_index          <= CFG_THRESHOLD;
    cfg_data           <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // ---- Directed part ----
    // Reset registers: threshold 30, eyes on channels 11 and 15.
    send_tick();                              // nothing detected, timer idle
    send_sample(4'd11, 24'sd30, 1'b0);
    send_sample(4'd15, 24'sd0, 1'b0);         // |L-R| sits exactly on threshold
    send_sample(4'd3, SAMPLE_MIN, 1'b1);      // frame end latches the detection

    // Max threshold, zero hold-off, same channel for both eyes.
    program_regs(THR_MAX, 16'd0, 15'h7fff, 4'd5, 4'd5);
    send_tick();                              // detection carried over -> on word
    send_tick();                              // zero hold expires at once: off, then on
    send_sample(4'd5, SAMPLE_MAX, 1'b1);      // L = R = max, below 2x max threshold
    send_tick();                              // off word only
    send_tick();                              // quiet

    // Zero threshold, left eye above right, one-tick hold-off.
    program_regs('0, 16'd1, 15'd0, 4'd15, 4'd0);
    send_sample(4'd0, -24'sd1, 1'b0);
    send_sample(4'd15, SAMPLE_MIN, 1'b1);     // zero threshold always hits
    send_tick();
    send_sample(4'd0, 24'sd1, 1'b1);          // later eye channel never arrives
    send_tick();                              // expiry, detection gone
    send_tick();

    // Sum path: |L+R| >= 2*threshold with L = R.
    program_regs(24'h400000, 16'd1, 15'h5555, 4'd1, 4'd9);
    send_sample(4'd1, 24'sd4194304, 1'b0);
    send_sample(4'd9, 24'sd4194304, 1'b1);    // sum lands exactly on 2*threshold
    send_tick();
    send_sample(4'd1, 24'sd4194303, 1'b0);
    send_sample(4'd9, 24'sd4194303, 1'b1);    // one below on each side: no hit
    send_tick();
    send_tick();

    // ---- Random part ----
    // Each phase: new register set, then mostly well-formed frames followed
    // by bursts of ticks, with some junk words and frames missing their end.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 54; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 54; end
        default: begin src_idle_pct = 17; snk_stall_pct = 17; end
      endcase
      span = 1 << $urandom_range(23, 3);
      thr  = THR_W'($urandom_range(span, 0));
      hold = HOLD_W'($urandom_range(6, 0));
      code = CODE_W'($urandom);
      lch  = CHAN_W'($urandom);
      rch  = CHAN_W'($urandom);
      case (ph)
        0: thr = '0;
        1: begin code = '1; lch = '0; rch = '1; hold = '0; end
        2: begin code = '0; rch = lch; end
        3: begin lch = '1; rch = '0; end
        RAND_PHASES - 1: begin thr = THR_MAX; hold = '1; span = 1 << 23; end
        default: ;
      endcase
      program_regs(thr, hold, code, lch, rch);
      later = int'((lch > rch) ? lch : rch);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9, 0) == 0) begin
          send_word(item_word_t'($urandom_range(1, 0) ? {$urandom, $urandom} : '0)
                    | item_word_t'({$urandom, $urandom}));
          sent++;
        end else begin
          // mostly long enough to reach the later eye channel
          len = ($urandom_range(3, 0) != 0) ? $urandom_range(CHANNELS, later + 1)
                                            : $urandom_range(CHANNELS, 1);
          drop_end = ($urandom_range(7, 0) == 0);
          for (int c = 0; c < len; c++) begin
            send_sample(CHAN_W'(c), pick_sample(span), (c == len - 1) && !drop_end);
            sent++;
          end
          burst = $urandom_range(4, 0);
          repeat (burst) begin
            send_tick();
            sent++;
          end
        end
      end
    end

    // ---- Wrap-up ----
    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
